@@ sv/phl_pkg.sv @@
// Shared types and constants of the two-level perfect hash lookup.
package phl_pkg;

  // Transaction commands
  localparam logic [1:0] CMD_BKT_WR  = 2'd0;
  localparam logic [1:0] CMD_SLOT_WR = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_TOP_FACTOR = 3'd0;
  localparam logic [2:0] CFG_TOP_SHIFT  = 3'd1;
  localparam logic [2:0] CFG_PRIME      = 3'd2;
  localparam logic [2:0] CFG_TOP_SIZE   = 3'd3;
  localparam logic [2:0] CFG_KEY_OFFSET = 3'd4;

  localparam int HashW = 64;  // width of a*x+b before reduction

  // Payload that travels with a transaction through the hash stages
  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] idx;
    logic [31:0] word;    // shifted key for lookups, raw key for slot writes
    logic [30:0] factor;
    logic [30:0] shift;
    logic [12:0] size;
    logic [11:0] base;
    logic        used;
    logic        err;
  } phl_side_t;

  // Payload of the second-level hash stages
  typedef struct packed {
    phl_side_t   side;
    logic        empty;
    logic [11:0] start;
    logic [12:0] slots;
  } phl_side2_t;

  // Bucket descriptor
  typedef struct packed {
    logic [30:0] factor;
    logic [30:0] shift;
    logic [12:0] slots;
    logic [11:0] start;
  } phl_bkt_t;

  // Slot entry
  typedef struct packed {
    logic        used;
    logic [31:0] key;
  } phl_slot_t;

endpackage

@@ sv/phl_mod.sv @@
// Pipelined remainder unit: one dividend bit per stage, zero divisor passes the dividend.
module phl_mod #(
  parameter int DW = 64,
  parameter int VW = 31,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] result_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [DW];
  logic [DW-1:0] dv_q   [DW];
  logic [VW-1:0] rem_q  [DW];
  logic [VW-1:0] div_q  [DW];
  logic [SW-1:0] side_q [DW];

  logic          vld_in  [DW];
  logic [DW-1:0] dv_in   [DW];
  logic [VW-1:0] rem_in  [DW];
  logic [VW-1:0] div_in  [DW];
  logic [SW-1:0] side_in [DW];
  logic [VW:0]   diff    [DW];

  // Select each stage's source: the ports for the first, the previous stage otherwise
  always_comb begin
    vld_in[0]  = valid_i;
    dv_in[0]   = dividend_i;
    rem_in[0]  = '0;
    div_in[0]  = divisor_i;
    side_in[0] = side_i;
    for (int i = 1; i < DW; i++) begin
      vld_in[i]  = vld_q[i-1];
      dv_in[i]   = dv_q[i-1];
      rem_in[i]  = rem_q[i-1];
      div_in[i]  = div_q[i-1];
      side_in[i] = side_q[i-1];
    end
  end

  // Shift in one dividend bit and subtract the divisor when it fits
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      if ({rem_in[i], dv_in[i][DW-1]} >= {1'b0, div_in[i]}) begin
        diff[i] = {rem_in[i], dv_in[i][DW-1]} - {1'b0, div_in[i]};
      end else begin
        diff[i] = {rem_in[i], dv_in[i][DW-1]};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DW; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      for (int i = 0; i < DW; i++) vld_q[i] <= vld_in[i];
    end
  end

  // Advance data; hold the dividend unshifted when the divisor is zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DW; i++) begin
        rem_q[i]  <= diff[i][VW-1:0];
        dv_q[i]   <= (div_in[i] == '0) ? dv_in[i] : {dv_in[i][DW-2:0], 1'b0};
        div_q[i]  <= div_in[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign valid_o  = vld_q[DW-1];
  assign side_o   = side_q[DW-1];
  assign result_o = (div_q[DW-1] == '0) ? dv_q[DW-1] : DW'(rem_q[DW-1]);

endmodule

@@ sv/two_level_perfect_hash_lookup.sv @@
// Top level of the two-level perfect hash membership lookup.
// Membership test in a two-level perfect hash set. Each transaction either writes a bucket
// descriptor, writes a slot, or looks up a key; only lookups return a result (found,
// range_error). One transaction is taken every cycle unless in_stall_o is high, and results
// leave in order after passing four 64-stage remainder pipelines (mod prime and mod
// top_size for the first level, mod prime and mod bucket size for the second), plus the
// multiply, add, bucket-store and slot-store stages. Writes take effect in transaction order
// with respect to lookups. After reset the block runs a clearing pass over the bucket and
// slot stores, holding in_stall_o high; configuration writes are taken meanwhile. Write
// configuration only while no lookup is in flight.
module two_level_perfect_hash_lookup #(
  parameter int BUCKETS = 1024,
  parameter int SLOTS   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [11:0] index_i,
  input  logic [31:0] key_i,
  input  logic [30:0] entry_factor_i,
  input  logic [30:0] entry_shift_i,
  input  logic [12:0] entry_size_i,
  input  logic [11:0] entry_base_i,
  input  logic        entry_valid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic        range_error_o
);

  import phl_pkg::*;

  localparam int BAW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CLR_N = (BUCKETS > SLOTS) ? BUCKETS : SLOTS;
  localparam int CW    = $clog2(CLR_N + 1);
  localparam int S1W   = $bits(phl_side_t);
  localparam int S2W   = $bits(phl_side2_t);

  // Configuration registers
  logic [30:0] top_factor_q, top_shift_q, prime_q, key_offset_q;
  logic [10:0] top_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_factor_q <= 31'd1;
      top_shift_q  <= '0;
      prime_q      <= 31'd1;
      top_size_q   <= 11'd1;
      key_offset_q <= '0;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_addr_i)
        CFG_TOP_FACTOR: top_factor_q <= cfg_wdata_i;
        CFG_TOP_SHIFT:  top_shift_q  <= cfg_wdata_i;
        CFG_PRIME:      prime_q      <= cfg_wdata_i;
        CFG_TOP_SIZE:   top_size_q   <= cfg_wdata_i[10:0];
        CFG_KEY_OFFSET: key_offset_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clearing pass over both stores after reset
  logic [CW-1:0] clr_cnt_q;
  logic          clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + CW'(1);
      if (clr_cnt_q == CW'(CLR_N - 1)) clr_busy_q <= 1'b0;
    end
  end

  // Global advance: freeze every pipeline stage while the output skid register holds a result
  logic adv, in_acc;
  logic out_vld_q, sk_vld_q;
  assign adv        = !sk_vld_q;
  assign in_stall_o = clr_busy_q || sk_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Stage 0: capture transaction and add the key offset
  logic [32:0] x_sum;
  phl_side_t   in_side;
  logic        p0_vld_q;
  phl_side_t   p0_side_q;

  always_comb begin
    x_sum          = {key_i[31], key_i} + {2'b00, key_offset_q};
    in_side.cmd    = command_i;
    in_side.idx    = index_i;
    in_side.word   = (command_i == CMD_LOOKUP) ? x_sum[31:0] : key_i;
    in_side.factor = entry_factor_i;
    in_side.shift  = entry_shift_i;
    in_side.size   = entry_size_i;
    in_side.base   = entry_base_i;
    in_side.used   = entry_valid_i;
    in_side.err    = x_sum[32] || (top_size_q == '0);
  end

  // Stages 1 and 2: first-level multiply, then add
  logic        p1_vld_q, p2_vld_q;
  phl_side_t   p1_side_q, p2_side_q;
  logic [62:0] prod1_q;
  logic [HashW-1:0] sum1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (adv) begin
      p0_vld_q <= in_acc;
      p1_vld_q <= p0_vld_q;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_side_q <= in_side;
      p1_side_q <= p0_side_q;
      prod1_q   <= 63'(top_factor_q) * 63'(p0_side_q.word);
      p2_side_q <= p1_side_q;
      sum1_q    <= HashW'(prod1_q) + HashW'(top_shift_q);
    end
  end

  // First level: mod prime, then mod top_size
  logic             m1_vld, m2_vld;
  logic [HashW-1:0] m1_res, m2_res;
  logic [S1W-1:0]   m1_side, m2_side;

  phl_mod #(.DW(HashW), .VW(31), .SW(S1W)) u_mod_p1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p2_vld_q), .dividend_i(sum1_q),
    .divisor_i(prime_q), .side_i(p2_side_q), .valid_o(m1_vld), .result_o(m1_res),
    .side_o(m1_side)
  );

  phl_mod #(.DW(HashW), .VW(11), .SW(S1W)) u_mod_top (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(m1_vld), .dividend_i(m1_res),
    .divisor_i(top_size_q), .side_i(m1_side), .valid_o(m2_vld), .result_o(m2_res),
    .side_o(m2_side)
  );

  // Bucket stage: range check, bucket store write or read
  phl_side_t m2_s, b_side_d;
  logic      bkt_we;
  logic [BAW-1:0] bkt_wa;
  phl_bkt_t  bkt_wd;
  phl_bkt_t  bkt_mem [BUCKETS];
  phl_bkt_t  bkt_rd_q;
  logic      b_vld_q;
  phl_side_t b_side_q;

  always_comb begin
    m2_s     = phl_side_t'(m2_side);
    b_side_d = m2_s;
    if (m2_res >= HashW'(BUCKETS)) b_side_d.err = 1'b1;
    if (clr_busy_q) begin
      bkt_we = (32'(clr_cnt_q) < 32'(BUCKETS));
      bkt_wa = BAW'(clr_cnt_q);
      bkt_wd = '0;
    end else begin
      bkt_we = adv && m2_vld && (m2_s.cmd == CMD_BKT_WR) && (32'(m2_s.idx) < 32'(BUCKETS));
      bkt_wa = BAW'(m2_s.idx);
      bkt_wd = '{factor: m2_s.factor, shift: m2_s.shift, slots: m2_s.size,
                 start: m2_s.base};
    end
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    if (adv) bkt_rd_q <= bkt_mem[m2_res[BAW-1:0]];
  end

  // Stages after the bucket read: second-level multiply, then add
  logic        b2_vld_q, b3_vld_q;
  phl_side2_t  b2_side_q, b3_side_q;
  logic [30:0] b2_shift_q;
  logic [62:0] prod2_q;
  logic [HashW-1:0] sum2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q  <= m2_vld;
      b2_vld_q <= b_vld_q;
      b3_vld_q <= b2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_side_q        <= b_side_d;
      prod2_q         <= 63'(bkt_rd_q.factor) * 63'(b_side_q.word);
      b2_shift_q      <= bkt_rd_q.shift;
      b2_side_q.side  <= b_side_q;
      b2_side_q.empty <= (bkt_rd_q.slots == '0);
      b2_side_q.start <= bkt_rd_q.start;
      b2_side_q.slots <= bkt_rd_q.slots;
      sum2_q          <= HashW'(prod2_q) + HashW'(b2_shift_q);
      b3_side_q       <= b2_side_q;
    end
  end

  // Second level: mod prime, then mod bucket size
  logic             m3_vld, m4_vld;
  logic [HashW-1:0] m3_res, m4_res;
  logic [S2W-1:0]   m3_side, m4_side;
  phl_side2_t       m3_s;

  assign m3_s = phl_side2_t'(m3_side);

  phl_mod #(.DW(HashW), .VW(31), .SW(S2W)) u_mod_p2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(b3_vld_q), .dividend_i(sum2_q),
    .divisor_i(prime_q), .side_i(b3_side_q), .valid_o(m3_vld), .result_o(m3_res),
    .side_o(m3_side)
  );

  phl_mod #(.DW(HashW), .VW(13), .SW(S2W)) u_mod_slot (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(m3_vld), .dividend_i(m3_res),
    .divisor_i(m3_s.slots), .side_i(m3_side), .valid_o(m4_vld), .result_o(m4_res),
    .side_o(m4_side)
  );

  // Slot stage: form slot address, range check, slot store write or read
  phl_side2_t m4_s, c_side_d;
  logic [13:0] slot_addr;
  logic        slot_we;
  logic [SAW-1:0] slot_wa;
  phl_slot_t   slot_wd;
  phl_slot_t   slot_mem [SLOTS];
  phl_slot_t   slot_rd_q;
  logic        c_vld_q;
  phl_side2_t  c_side_q;

  always_comb begin
    m4_s      = phl_side2_t'(m4_side);
    slot_addr = 14'(m4_s.start) + 14'(m4_res[12:0]);
    c_side_d  = m4_s;
    if (!m4_s.empty && (32'(slot_addr) >= 32'(SLOTS))) c_side_d.side.err = 1'b1;
    if (clr_busy_q) begin
      slot_we = (32'(clr_cnt_q) < 32'(SLOTS));
      slot_wa = SAW'(clr_cnt_q);
      slot_wd = '0;
    end else begin
      slot_we = adv && m4_vld && (m4_s.side.cmd == CMD_SLOT_WR) &&
                (32'(m4_s.side.idx) < 32'(SLOTS));
      slot_wa = SAW'(m4_s.side.idx);
      slot_wd = '{used: m4_s.side.used, key: m4_s.side.word};
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (adv) slot_rd_q <= slot_mem[SAW'(slot_addr)];
  end

  // Compare, then output register with a skid register behind it
  logic found_d, res_vld, out_free;
  logic found_q, err_q;
  logic sk_found_q, sk_err_q;

  assign found_d  = !c_side_q.side.err && !c_side_q.empty && slot_rd_q.used &&
                    !c_side_q.side.word[31] && (slot_rd_q.key == c_side_q.side.word);
  assign res_vld  = c_vld_q && (c_side_q.side.cmd == CMD_LOOKUP);
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else begin
      if (adv) c_vld_q <= m4_vld;
      if (sk_vld_q) begin
        if (out_free) begin
          out_vld_q <= 1'b1;
          sk_vld_q  <= 1'b0;
        end
      end else if (out_free) begin
        out_vld_q <= res_vld;
      end else if (res_vld) begin
        sk_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) c_side_q <= c_side_d;
    if (sk_vld_q) begin
      if (out_free) begin
        found_q <= sk_found_q;
        err_q   <= sk_err_q;
      end
    end else if (out_free) begin
      found_q <= found_d;
      err_q   <= c_side_q.side.err;
    end else if (res_vld) begin
      sk_found_q <= found_d;
      sk_err_q   <= c_side_q.side.err;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign found_o       = found_q;
  assign range_error_o = err_q;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the two-level perfect hash membership lookup.
`timescale 1ns / 100ps

import phl_pkg::*;

// Expected-verdict tracker: keeps its own copy of the tables and registers.
class hash_set_model;
  localparam int NumBuckets = 1024;
  localparam int NumSlots   = 4096;

  bit [30:0] top_factor = 1, top_shift = 0, prime = 1, key_offset = 0;
  bit [10:0] top_size = 1;
  bit [30:0] bkt_factor[NumBuckets];
  bit [30:0] bkt_shift[NumBuckets];
  bit [12:0] bkt_slots[NumBuckets];
  bit [11:0] bkt_start[NumBuckets];
  bit [31:0] slot_key[NumSlots];
  bit        slot_used[NumSlots];
  bit [1:0]  verdict_q[$];  // {found, range_error} per outstanding lookup
  int        mismatches;

  function void set_reg(bit [2:0] addr, bit [30:0] data);
    case (addr)
      CFG_TOP_FACTOR: top_factor = data;
      CFG_TOP_SHIFT:  top_shift  = data;
      CFG_PRIME:      prime      = data;
      CFG_TOP_SIZE:   top_size   = data[10:0];
      CFG_KEY_OFFSET: key_offset = data;
      default: ;
    endcase
  endfunction

  function longint unsigned mix(longint unsigned a, longint unsigned b,
                                longint unsigned p, longint unsigned x);
    longint unsigned v;
    v = a * x + b;
    return (p != 0) ? v % p : v;
  endfunction

  // Walk both hash levels for a shifted key; slot_idx stays -1 if none is chosen.
  function void locate(longint x, output int slot_idx, output bit err);
    longint unsigned ux, b, s;
    slot_idx = -1;
    err = 0;
    if (x < 0 || top_size == 0) begin
      err = 1;
    end else begin
      ux = x;
      b = mix(top_factor, top_shift, prime, ux) % top_size;
      if (b >= NumBuckets) begin
        err = 1;
      end else if (bkt_slots[b] != 0) begin
        s = bkt_start[b] + mix(bkt_factor[b], bkt_shift[b], prime, ux) % bkt_slots[b];
        if (s >= NumSlots) err = 1;
        else slot_idx = int'(s);
      end
    end
  endfunction

  // Apply one accepted transaction; lookups queue their expected verdict.
  function void note_input(bit [1:0] cmd, bit [11:0] idx, bit [31:0] key, bit [30:0] fac,
                           bit [30:0] sh, bit [12:0] sz, bit [11:0] base, bit vld);
    longint x;
    int     sl;
    bit     err, hit;
    case (cmd)
      CMD_BKT_WR: if (idx < NumBuckets) begin
        bkt_factor[idx] = fac;
        bkt_shift[idx]  = sh;
        bkt_slots[idx]  = sz;
        bkt_start[idx]  = base;
      end
      CMD_SLOT_WR: begin
        slot_key[idx]  = key;
        slot_used[idx] = vld;
      end
      CMD_LOOKUP: begin
        x = longint'($signed(key)) + longint'(key_offset);
        locate(x, sl, err);
        hit = (sl >= 0) && slot_used[sl] && (longint'($signed(slot_key[sl])) == x);
        verdict_q.push_back({hit, err});
      end
      default: ;
    endcase
  endfunction

  function void check_result(bit found, bit range_err);
    bit [1:0] want;
    if (verdict_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result found=%0b range_error=%0b", $realtime, found,
                 range_err);
      return;
    end
    want = verdict_q.pop_front();
    if (want != {found, range_err}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: found exp %0b got %0b, range_error exp %0b got %0b", $realtime,
                 want[1], found, want[0], range_err);
    end
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction
endclass

module tb;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 300;
  localparam int HoldCycles    = 1500;

  logic        clk_i, rst_ni;
  logic        cfg_wr_en_i;
  logic [2:0]  cfg_addr_i;
  logic [30:0] cfg_wdata_i;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  command_i;
  logic [11:0] index_i;
  logic [31:0] key_i;
  logic [30:0] entry_factor_i, entry_shift_i;
  logic [12:0] entry_size_i;
  logic [11:0] entry_base_i;
  logic        entry_valid_i;
  logic        out_valid_o, out_stall_i, found_o, range_error_o;

  hash_set_model sb = new();
  bit            quiet;
  bit            hold_req;
  int            idle_cycles;
  logic [31:0]   members[$];

  two_level_perfect_hash_lookup u_dut (.*);

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, occasionally long
  function automatic int next_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Check every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(found_o, range_error_o);
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 0;
        out_stall_i <= 1'b0;
      end else begin
        n = next_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Offer one transaction, hold it until taken, then maybe idle
  task automatic send(bit [1:0] cmd, bit [11:0] idx, bit [31:0] key, bit [30:0] fac,
                      bit [30:0] sh, bit [12:0] sz, bit [11:0] base, bit vld);
    int n;
    command_i <= cmd;
    index_i <= idx;
    key_i <= key;
    entry_factor_i <= fac;
    entry_shift_i <= sh;
    entry_size_i <= sz;
    entry_base_i <= base;
    entry_valid_i <= vld;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.note_input(cmd, idx, key, fac, sh, sz, base, vld);
    n = next_gap();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic lookup(bit [31:0] key);
    send(CMD_LOOKUP, 12'($urandom), key, 31'($urandom), 31'($urandom), 13'($urandom),
         12'($urandom), 1'($urandom));
  endtask

  // Drop valid and wait until every lookup has returned and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all five registers back to back
  task automatic write_regs(bit [30:0] fac, bit [30:0] sh, bit [30:0] p, bit [10:0] sz,
                            bit [30:0] off);
    bit [30:0] vals[5];
    bit [2:0]  addrs[5];
    vals = '{fac, sh, p, 31'(sz), off};
    addrs = '{CFG_TOP_FACTOR, CFG_TOP_SHIFT, CFG_PRIME, CFG_TOP_SIZE, CFG_KEY_OFFSET};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en_i <= 1'b1;
      cfg_addr_i <= addrs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(addrs[i], vals[i]);
    end
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic directed_keys();
    lookup(32'd5);
    lookup(32'd6);
    lookup(32'hFFFF_FFFF);
    lookup(32'h8000_0000);
    lookup(32'h7FFF_FFFF);
  endtask

  initial begin
    bit [30:0] primes[6];
    bit [30:0] pr, off;
    bit [10:0] tsz;
    longint    x;
    int        sl, r, nb, nq;
    bit        err;

    primes = '{31'd2147483647, 31'd1000003, 31'd65537, 31'd7919, 31'd0, 31'd1};
    rst_ni = 1'b0;
    cfg_wr_en_i = 1'b0;
    cfg_addr_i = CFG_TOP_FACTOR;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_LOOKUP;
    index_i = '0;
    key_i = '0;
    entry_factor_i = '0;
    entry_shift_i = '0;
    entry_size_i = '0;
    entry_base_i = '0;
    entry_valid_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers, empty table, then one full bucket
    lookup(32'd5);
    send(CMD_BKT_WR, 12'd0, '0, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 13'd4096, 12'd0, 1'b1);
    send(CMD_SLOT_WR, 12'd0, 32'd5, '0, '0, '0, '0, 1'b1);
    directed_keys();
    send(CMD_IGNORED, 12'd0, 32'd6, '0, '0, '0, '0, 1'b1);
    send(CMD_BKT_WR, 12'hFFF, '0, '0, '0, 13'd1, 12'd0, 1'b0);
    send(CMD_SLOT_WR, 12'hFFF, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0);
    // Directed: prime zero, bucket index past the table, top offset
    settle();
    write_regs(31'h7FFF_FFFE, 31'h7FFF_FFFE, 31'd0, 11'd2047, 31'h7FFF_FFFF);
    directed_keys();
    // Directed: no buckets at all
    settle();
    write_regs(31'd1, 31'd0, 31'd1, 11'd0, 31'd0);
    directed_keys();
    // Directed: slot address past the slot store
    settle();
    write_regs(31'd1, 31'd0, 31'd0, 11'd1, 31'd0);
    send(CMD_BKT_WR, 12'd0, '0, 31'd1, 31'd0, 13'd4096, 12'hFFF, 1'b0);
    directed_keys();

    // Random phases: build a table, then query it
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      quiet = (ph == 2 || ph == 3);
      case (ph)
        0: write_regs(31'h7FFF_FFFE, 31'h7FFF_FFFE, 31'h7FFF_FFFF, 11'd1024, 31'h7FFF_FFFF);
        1: write_regs(31'd0, 31'd0, 31'd1, 11'd1, 31'd0);
        default: begin
          pr = primes[$urandom_range(0, 5)];
          tsz = ($urandom_range(0, 3) == 0) ? 11'd1024 : 11'($urandom_range(1, 16));
          off = ($urandom_range(0, 1) == 0) ? 31'd0 : 31'($urandom);
          write_regs(31'($urandom_range(0, 2147483646)),
                     31'($urandom_range(0, 2147483646)), pr, tsz, off);
        end
      endcase
      members.delete();
      nb = (sb.top_size > 24) ? 24 : sb.top_size;
      for (int i = 0; i < nb; i++) begin
        r = $urandom_range(0, 99);
        send(CMD_BKT_WR, 12'($urandom_range(0, sb.top_size - 1)), $urandom,
             31'($urandom_range(0, 2147483646)), 31'($urandom_range(0, 2147483646)),
             (r < 10) ? 13'd0 : (r < 15) ? 13'd4096 : 13'($urandom_range(1, 8)),
             ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom), 1'b0);
      end
      // Insert members at the slot each one hashes to
      for (int i = 0; i < 40; i++) begin
        x = $urandom_range(0, 2147483647);
        sb.locate(x, sl, err);
        members.push_back(32'(x - longint'(sb.key_offset)));
        if (sl >= 0)
          send(CMD_SLOT_WR, 12'(sl), 32'(x), 31'($urandom), 31'($urandom), 13'($urandom),
               12'($urandom), $urandom_range(0, 7) != 0);
      end
      // The hold phase sends enough back to back to fill the pipe and stall the input
      if (ph == 3) hold_req = 1;
      nq = (ph == 3) ? 400 : 70;
      for (int i = 0; i < nq; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) lookup(members[$urandom_range(0, members.size() - 1)]);
        else if (r < 65) lookup($urandom);
        else if (r < 72) lookup(members[$urandom_range(0, members.size() - 1)] + 1);
        else if (r < 80)
          send(CMD_SLOT_WR, 12'($urandom), $urandom, 31'($urandom), 31'($urandom),
               13'($urandom), 12'($urandom), 1'($urandom));
        else if (r < 85)
          send(CMD_BKT_WR, 12'($urandom), $urandom, 31'($urandom_range(0, 2147483646)),
               31'($urandom_range(0, 2147483646)), 13'($urandom_range(0, 4096)),
               12'($urandom), 1'($urandom));
        else if (r < 88)
          send(CMD_IGNORED, 12'($urandom), $urandom, 31'($urandom), 31'($urandom),
               13'($urandom), 12'($urandom), 1'($urandom));
        else lookup(32'(-longint'(sb.key_offset) - $urandom_range(1, 1000)));
      end
    end

    // Drain and report
    quiet = 0;
    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/phl_pkg.sv
sv/phl_mod.sv
sv/two_level_perfect_hash_lookup.sv
tb/sv/tb.sv
